### rtl/bcs_pkg.sv
// Shared types and constants for the Bezier curve sampler.
package bcs_pkg;

  localparam int MAX_STEPS = 64;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int W_W       = 3 * IDX_W;
  localparam int PROD_W    = 32 + W_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_W     = SUM_W - 1;
  localparam int Q_W       = 32;

  localparam logic FUNC_QUAD  = 1'b0;
  localparam logic FUNC_CUBIC = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic [7:0]         sample_count;
  } curve_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              cubic;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  d;
    logic [3:0][31:0]  px;
    logic [3:0][31:0]  py;
  } issue_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] mag_x;
    logic [NUM_W-1:0] mag_y;
    logic [W_W-1:0]   den;
  } div_in_t;

endpackage

### rtl/bezier_curve_sampler_top.sv
// Top level of the Bezier curve sampler.
//
// One beat on the input carries a quadratic or cubic curve (signed Q16.16 control
// points) and a sample count; a count below 2 or above MAX_STEPS means MAX_STEPS.
// The block then emits n points B(i/(n-1)), i = 0..n-1, each rounded to the
// nearest Q16.16 value (ties away from zero), one point per cycle, with last set
// on the final one. Busy is high until the final index of a curve is issued, and a
// new curve may be started in the very cycle that index goes out, so back-to-back
// curves stream without gaps. Between the issue of an index and its point lie five
// stages of weights, products and sums, 32 stages of the restoring divider (one
// quotient bit each), and an output register. Each point is on the outputs for one
// cycle only, marked by point_valid; the receiver cannot stall, and no point is
// ever held back.
module bezier_curve_sampler_top import bcs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  curve_t curve,
  output logic   point_valid,
  output point_t point
);

  issue_t  issue;
  div_in_t div_in;

  // The sequencer holds the accepted curve and walks the sample index.
  bcs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .curve (curve),
    .issue (issue)
  );

  // Weights and weighted sums produce the exact rational numerator.
  bcs_weight u_weight (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .dout  (div_in)
  );

  // The divider turns the numerator into the rounded point.
  bcs_div u_div (
    .clk         (clk),
    .rst         (rst),
    .din         (div_in),
    .point_valid (point_valid),
    .point       (point)
  );

  // An accepted curve always issues at least two points, so the sequencer is active.
  a_accept_issues: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> issue.valid)
    else $error("accepted curve did not start issuing");

  // Busy drops exactly in the cycle in which the final index of a curve goes out.
  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> issue.valid && issue.last)
    else $error("busy dropped before final index");

  // The first index of a curve has full weight on the start point.
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> issue.a == issue.d)
    else $error("first issued index is not zero");

endmodule

### rtl/bcs_seq.sv
// Curve sequencer: holds one curve and issues one sample index per cycle.
module bcs_seq import bcs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  curve_t curve,
  output issue_t issue
);

  logic             active;
  logic             cubic;
  logic [IDX_W-1:0] d;
  logic [IDX_W-1:0] i;
  logic [3:0][31:0] px;
  logic [3:0][31:0] py;
  logic [IDX_W-1:0] d_next;
  logic             at_end;
  logic             accept;

  assign at_end = (i == d);
  assign busy   = active && !at_end;
  assign accept = start && !busy;

  always_comb begin
    if (curve.sample_count < 8'd2 || curve.sample_count > 8'(MAX_STEPS)) begin
      d_next = IDX_W'(MAX_STEPS - 1);
    end else begin
      d_next = IDX_W'(curve.sample_count - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      i      <= '0;
    end else if (accept) begin
      active <= 1'b1;
      i      <= '0;
      d      <= d_next;
      cubic  <= (curve.func == FUNC_CUBIC);
      px     <= {curve.p3_x, curve.p2_x, curve.p1_x, curve.p0_x};
      py     <= {curve.p3_y, curve.p2_y, curve.p1_y, curve.p0_y};
    end else if (active) begin
      if (at_end) begin
        active <= 1'b0;
      end else begin
        i <= i + IDX_W'(1);
      end
    end
  end

  always_comb begin
    issue.valid = active;
    issue.last  = at_end;
    issue.cubic = cubic;
    issue.a     = d - i;
    issue.b     = i;
    issue.d     = d;
    issue.px    = px;
    issue.py    = py;
  end

endmodule

### rtl/bcs_weight.sv
// Bernstein weights, weighted sums and rounding offset, five register stages.
module bcs_weight import bcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  issue_t  issue,
  output div_in_t dout
);

  // Stage 1: squares and cross product.
  issue_t             s1;
  logic [2*IDX_W-1:0] aa, ab, bb, dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= issue.valid;
    end
    s1.last  <= issue.last;
    s1.cubic <= issue.cubic;
    s1.a     <= issue.a;
    s1.b     <= issue.b;
    s1.d     <= issue.d;
    s1.px    <= issue.px;
    s1.py    <= issue.py;
    aa <= (2*IDX_W)'(issue.a) * (2*IDX_W)'(issue.a);
    ab <= (2*IDX_W)'(issue.a) * (2*IDX_W)'(issue.b);
    bb <= (2*IDX_W)'(issue.b) * (2*IDX_W)'(issue.b);
    dd <= (2*IDX_W)'(issue.d) * (2*IDX_W)'(issue.d);
  end

  // Stage 2: final weights and denominator.
  logic             v2, l2;
  logic [3:0][31:0] px2, py2;
  logic [3:0][W_W-1:0] w2;
  logic [W_W-1:0]   den2;
  logic [W_W-1:0]   aab, abb;

  assign aab = W_W'(aa) * W_W'(s1.b);
  assign abb = W_W'(ab) * W_W'(s1.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= s1.valid;
    end
    l2  <= s1.last;
    px2 <= s1.px;
    py2 <= s1.py;
    if (s1.cubic) begin
      w2[0] <= W_W'(aa) * W_W'(s1.a);
      w2[1] <= W_W'(aab + {aab[W_W-2:0], 1'b0});
      w2[2] <= W_W'(abb + {abb[W_W-2:0], 1'b0});
      w2[3] <= W_W'(bb) * W_W'(s1.b);
      den2  <= W_W'(dd) * W_W'(s1.d);
    end else begin
      w2[0] <= W_W'(aa);
      w2[1] <= W_W'({ab, 1'b0});
      w2[2] <= W_W'(bb);
      w2[3] <= '0;
      den2  <= W_W'(dd);
    end
  end

  // Stage 3: coordinate times weight.
  logic                     v3, l3;
  logic [W_W-1:0]           den3;
  logic signed [PROD_W-1:0] prx [4];
  logic signed [PROD_W-1:0] pry [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    l3   <= l2;
    den3 <= den2;
    for (int k = 0; k < 4; k++) begin
      prx[k] <= PROD_W'($signed(px2[k])) * PROD_W'($signed({1'b0, w2[k]}));
      pry[k] <= PROD_W'($signed(py2[k])) * PROD_W'($signed({1'b0, w2[k]}));
    end
  end

  // Stage 4: sums of four products.
  logic                    v4, l4;
  logic [W_W-1:0]          den4;
  logic signed [SUM_W-1:0] sx, sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    l4   <= l3;
    den4 <= den3;
    sx   <= SUM_W'(prx[0]) + SUM_W'(prx[1]) + SUM_W'(prx[2]) + SUM_W'(prx[3]);
    sy   <= SUM_W'(pry[0]) + SUM_W'(pry[1]) + SUM_W'(pry[2]) + SUM_W'(pry[3]);
  end

  // Stage 5: magnitude plus half the denominator, sign kept aside.
  logic [SUM_W-1:0] abs_x, abs_y;

  assign abs_x = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign abs_y = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= v4;
    end
    dout.last  <= l4;
    dout.neg_x <= sx[SUM_W-1];
    dout.neg_y <= sy[SUM_W-1];
    dout.mag_x <= NUM_W'(abs_x) + NUM_W'(den4 >> 1);
    dout.mag_y <= NUM_W'(abs_y) + NUM_W'(den4 >> 1);
    dout.den   <= den4;
  end

endmodule

### rtl/bcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, both coordinates.
module bcs_div import bcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  div_in_t din,
  output logic    point_valid,
  output point_t  point
);

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] r_x;
    logic [NUM_W-1:0] r_y;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
    logic [W_W-1:0]   den;
  } dstage_t;

  dstage_t st [Q_W+1];

  always_comb begin
    st[0].valid = din.valid;
    st[0].last  = din.last;
    st[0].neg_x = din.neg_x;
    st[0].neg_y = din.neg_y;
    st[0].r_x   = din.mag_x;
    st[0].r_y   = din.mag_y;
    st[0].q_x   = '0;
    st[0].q_y   = '0;
    st[0].den   = din.den;
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    localparam int J = Q_W - 1 - g;
    logic [NUM_W-1:0] den_w;
    logic             ge_x, ge_y;
    dstage_t          st_next;

    assign den_w = NUM_W'(st[g].den);
    assign ge_x  = (st[g].r_x >> J) >= den_w;
    assign ge_y  = (st[g].r_y >> J) >= den_w;

    always_comb begin
      st_next       = st[g];
      st_next.valid = st[g].valid && !rst;
      if (ge_x) begin
        st_next.r_x    = st[g].r_x - (den_w << J);
        st_next.q_x[J] = 1'b1;
      end
      if (ge_y) begin
        st_next.r_y    = st[g].r_y - (den_w << J);
        st_next.q_y[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      st[g+1] <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      point_valid <= st[Q_W].valid;
    end
    point.last    <= st[Q_W].last;
    point.point_x <= st[Q_W].neg_x ? -st[Q_W].q_x : st[Q_W].q_x;
    point.point_y <= st[Q_W].neg_y ? -st[Q_W].q_y : st[Q_W].q_y;
  end

endmodule
